/* rtl/core/uniform_int_dte_codec_unit_defines.svh */
// Assertion macros shared by the codec RTL.
`ifndef UNIFORM_INT_DTE_CODEC_UNIT_DEFINES_SVH
`define UNIFORM_INT_DTE_CODEC_UNIT_DEFINES_SVH

// Same-cycle implication.
`define UDC_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define UDC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/udc_pkg.sv */
package udc_pkg;

   localparam int DEF_IN_WIDTH = 32;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_INDEX_W  = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_SIGNED_MODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_VALUE   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_VALUE   = 2'd2;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_LOW    = 2'd1;
   localparam logic [1:0] ST_HIGH   = 2'd2;
   localparam logic [1:0] ST_BOUNDS = 2'd3;

   localparam logic FUNC_ENCODE = 1'b0;
   localparam logic FUNC_DECODE = 1'b1;

   typedef struct packed {
      logic        func;
      logic [31:0] value;
      logic [63:0] random_word;
      logic [63:0] code_word;
      logic        last_item;
   } req_type;

   typedef struct packed {
      logic [63:0] result_word;
      logic [1:0]  status;
      logic        last_out;
   } rsp_type;

endpackage

/* rtl/core/udc_div_cell.sv */
module udc_div_cell
   import udc_pkg::*;
#(
   parameter int DW = 33,
   parameter int NW = 64,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic          in_valid,
   input  logic [DW-1:0] in_div,
   input  logic [DW-1:0] in_rem,
   input  logic [NW-1:0] in_num,
   input  logic [NW-1:0] in_quot,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [DW-1:0] out_div,
   output logic [DW-1:0] out_rem,
   output logic [NW-1:0] out_num,
   output logic [NW-1:0] out_quot,
   output logic [SW-1:0] out_side
);

   logic          valid_ff;
   logic [DW-1:0] div_ff, rem_ff, rem_in;
   logic [NW-1:0] num_ff, quot_ff;
   logic [SW-1:0] side_ff;
   logic [DW:0]   trial, diff;
   logic          ge;

   always_comb begin
      trial  = {in_rem, in_num[NW-1]};
      diff   = trial - {1'b0, in_div};
      ge     = trial >= {1'b0, in_div};
      rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         div_ff  <= in_div;
         rem_ff  <= rem_in;
         num_ff  <= {in_num[NW-2:0], 1'b0};
         quot_ff <= {in_quot[NW-2:0], ge};
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_div   = div_ff;
   assign out_rem   = rem_ff;
   assign out_num   = num_ff;
   assign out_quot  = quot_ff;
   assign out_side  = side_ff;

endmodule

/* rtl/core/udc_div_chain.sv */
module udc_div_chain
   import udc_pkg::*;
#(
   parameter int DW = 33,
   parameter int NW = 64,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic          in_valid,
   input  logic [DW-1:0] in_div,
   input  logic [NW-1:0] in_num,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [DW-1:0] out_div,
   output logic [DW-1:0] out_rem,
   output logic [NW-1:0] out_quot,
   output logic [SW-1:0] out_side
);

   logic          v_w    [0:NW];
   logic [DW-1:0] div_w  [0:NW];
   logic [DW-1:0] rem_w  [0:NW];
   logic [NW-1:0] num_w  [0:NW];
   logic [NW-1:0] quot_w [0:NW];
   logic [SW-1:0] side_w [0:NW];

   assign v_w[0]    = in_valid;
   assign div_w[0]  = in_div;
   assign rem_w[0]  = '0;
   assign num_w[0]  = in_num;
   assign quot_w[0] = '0;
   assign side_w[0] = in_side;

   for (genvar i = 0; i < NW; i++) begin : g_cell
      udc_div_cell #(.DW(DW), .NW(NW), .SW(SW)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .in_valid (v_w[i]),
         .in_div   (div_w[i]),
         .in_rem   (rem_w[i]),
         .in_num   (num_w[i]),
         .in_quot  (quot_w[i]),
         .in_side  (side_w[i]),
         .out_valid(v_w[i+1]),
         .out_div  (div_w[i+1]),
         .out_rem  (rem_w[i+1]),
         .out_num  (num_w[i+1]),
         .out_quot (quot_w[i+1]),
         .out_side (side_w[i+1])
      );
   end

   assign out_valid = v_w[NW];
   assign out_div   = div_w[NW];
   assign out_rem   = rem_w[NW];
   assign out_quot  = quot_w[NW];
   assign out_side  = side_w[NW];

endmodule

/* rtl/core/uniform_int_dte_codec_unit.sv */
// Throughput: one word per cycle; the whole pipeline holds while a result waits.
// Two chains of 2*IN_WIDTH restoring-division cells set the latency.
// Synchronous active-high reset empties the pipeline and loads signed_mode 0,
// min_value 0 and max_value all ones.
`include "uniform_int_dte_codec_unit_defines.svh"

module uniform_int_dte_codec_unit
   import udc_pkg::*;
#(
   parameter int IN_WIDTH = DEF_IN_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_word,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int W = IN_WIDTH;
   localparam int N = 2 * IN_WIDTH;

   typedef struct packed {
      logic         func;
      logic [1:0]   st;
      logic         full;
      logic         single;
      logic         last;
      logic [W-1:0] off;
      logic [W-1:0] lo;
      logic [W-1:0] plain;
      logic [N-1:0] rnd;
   } side1_type;

   typedef struct packed {
      logic         func;
      logic [1:0]   st;
      logic         full;
      logic         single;
      logic         last;
      logic [W-1:0] off;
      logic [W-1:0] gs;
      logic [W-1:0] dec;
      logic [W-1:0] plain;
      logic [N-1:0] rnd;
   } side2_type;

   localparam int S1W = $bits(side1_type);
   localparam int S2W = $bits(side2_type);

   logic            signed_ff;
   logic [31:0]     min_ff, max_ff;
   logic            adv;

   logic [W-1:0]    sbit, kmin, kmax, kv, lo;
   logic [W:0]      gs;
   logic            bad;
   logic [1:0]      st0;
   side1_type       s0_side_in, s0_side_ff;
   logic [W:0]      s0_div_ff;
   logic [N-1:0]    s0_num_ff;
   logic            s0_valid_ff;

   logic            d1_valid;
   logic [W:0]      d1_div, d1_rem;
   logic [N-1:0]    d1_quot;
   logic [S1W-1:0]  d1_side_raw;
   side1_type       d1_side;

   logic [N-1:0]    groups, d2;
   logic [W:0]      r0p1, last_gs;
   logic            use_all;
   side2_type       s1_side_in, s1_side_ff;
   logic [N-1:0]    s1_div_ff;
   logic            s1_valid_ff;

   logic            d2_valid;
   logic [N-1:0]    d2_div, d2_rem, d2_quot;
   logic [S2W-1:0]  d2_side_raw;
   side2_type       d2_side;

   logic            m1_valid_ff;
   side2_type       m1_side_ff;
   logic [N-1:0]    plo_ff;
   logic [W-1:0]    phi_ff;
   logic [N-1:0]    phi_full;
   logic [N-1:0]    res_enc;
   logic [N-1:0]    res_in;

   logic            rsp_valid_ff;
   rsp_type         rsp_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         signed_ff <= 1'b0;
         min_ff    <= '0;
         max_ff    <= '1;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SIGNED_MODE: signed_ff <= csr_data[0];
            CSR_MIN_VALUE:   min_ff    <= csr_data;
            CSR_MAX_VALUE:   max_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      sbit  = signed_ff ? {1'b1, {(W-1){1'b0}}} : '0;
      kmin  = min_ff[W-1:0] ^ sbit;
      kmax  = max_ff[W-1:0] ^ sbit;
      kv    = req_word.value[W-1:0] ^ sbit;
      lo    = min_ff[W-1:0];
      bad   = kmin > kmax;
      gs    = {1'b0, kmax} - {1'b0, kmin} + (W+1)'(1);
      if (bad) begin
         st0 = ST_BOUNDS;
      end else if (req_word.func == FUNC_DECODE) begin
         st0 = ST_OK;
      end else if (kv < kmin) begin
         st0 = ST_LOW;
      end else if (kv > kmax) begin
         st0 = ST_HIGH;
      end else begin
         st0 = ST_OK;
      end
      s0_side_in.func   = req_word.func;
      s0_side_in.st     = st0;
      s0_side_in.full   = gs[W];
      s0_side_in.single = gs == (W+1)'(1);
      s0_side_in.last   = req_word.last_item;
      s0_side_in.off    = kv - kmin;
      s0_side_in.lo     = lo;
      s0_side_in.plain  = (req_word.func == FUNC_DECODE) ? req_word.code_word[W-1:0]
                                                         : req_word.value[W-1:0];
      s0_side_in.rnd    = req_word.random_word[N-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req_valid;
      end
      if (adv) begin
         s0_side_ff <= s0_side_in;
         s0_div_ff  <= gs;
         s0_num_ff  <= (req_word.func == FUNC_DECODE) ? req_word.code_word[N-1:0] : '1;
      end
   end

   udc_div_chain #(.DW(W+1), .NW(N), .SW(S1W)) u_div_grp (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (s0_valid_ff),
      .in_div   (s0_div_ff),
      .in_num   (s0_num_ff),
      .in_side  (s0_side_ff),
      .out_valid(d1_valid),
      .out_div  (d1_div),
      .out_rem  (d1_rem),
      .out_quot (d1_quot),
      .out_side (d1_side_raw)
   );

   always_comb begin
      d1_side = side1_type'(d1_side_raw);
      groups  = d1_quot + N'(1);
      r0p1    = d1_rem + (W+1)'(1);
      last_gs = (r0p1 == d1_div) ? '0 : r0p1;
      use_all = (last_gs == '0) || ({1'b0, d1_side.off} < last_gs);
      d2      = use_all ? groups : groups - N'(1);
      s1_side_in.func   = d1_side.func;
      s1_side_in.st     = d1_side.st;
      s1_side_in.full   = d1_side.full;
      s1_side_in.single = d1_side.single;
      s1_side_in.last   = d1_side.last;
      s1_side_in.off    = d1_side.off;
      s1_side_in.gs     = d1_div[W-1:0];
      s1_side_in.dec    = d1_rem[W-1:0] + d1_side.lo;
      s1_side_in.plain  = d1_side.single ? d1_side.lo : d1_side.plain;
      s1_side_in.rnd    = d1_side.rnd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= d1_valid;
      end
      if (adv) begin
         s1_side_ff <= s1_side_in;
         s1_div_ff  <= d2;
      end
   end

   udc_div_chain #(.DW(N), .NW(N), .SW(S2W)) u_div_idx (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (s1_valid_ff),
      .in_div   (s1_div_ff),
      .in_num   (s1_side_ff.rnd),
      .in_side  (s1_side_ff),
      .out_valid(d2_valid),
      .out_div  (d2_div),
      .out_rem  (d2_rem),
      .out_quot (d2_quot),
      .out_side (d2_side_raw)
   );

   assign d2_side = side2_type'(d2_side_raw);

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else if (adv) begin
         m1_valid_ff <= d2_valid;
      end
      if (adv) begin
         m1_side_ff <= d2_side;
         plo_ff     <= N'(d2_rem[W-1:0] * d2_side.gs);
         phi_ff     <= W'(d2_rem[N-1:W] * d2_side.gs);
      end
   end

   always_comb begin
      phi_full = {phi_ff, {W{1'b0}}};
      res_enc  = N'(m1_side_ff.off) + plo_ff + phi_full;
      if (m1_side_ff.st != ST_OK) begin
         res_in = '0;
      end else if (m1_side_ff.func == FUNC_DECODE) begin
         res_in = (m1_side_ff.full || m1_side_ff.single) ? N'(m1_side_ff.plain)
                                                          : N'(m1_side_ff.dec);
      end else if (m1_side_ff.full) begin
         res_in = {m1_side_ff.rnd[W-1:0], m1_side_ff.plain};
      end else if (m1_side_ff.single) begin
         res_in = m1_side_ff.rnd;
      end else begin
         res_in = res_enc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= m1_valid_ff;
      end
      if (adv) begin
         rsp_ff.result_word <= 64'(res_in);
         rsp_ff.status      <= m1_side_ff.st;
         rsp_ff.last_out    <= m1_side_ff.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   `UDC_ASSERT_IMPL(a_err_zero, rsp_valid_ff && (rsp_ff.status != ST_OK), rsp_ff.result_word == '0, "error word carries nonzero result")
   `UDC_ASSERT_IMPL(a_div_nonzero, s1_valid_ff && (s1_side_ff.st == ST_OK) && (s1_side_ff.func == FUNC_ENCODE) && !s1_side_ff.full && !s1_side_ff.single, s1_div_ff != '0, "zero group count")
   `UDC_ASSERT_NEXT(a_stall_hold, !adv, s0_valid_ff == $past(s0_valid_ff), "pipeline moved while stalled")

endmodule

/* bench/udc_checker.sv */
`timescale 1ns / 100ps

module udc_checker
   import udc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  req_type                req_word,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rsp_type                rsp_word,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     fail_count,
   output int                     pending
);

   logic        cfg_signed;
   logic [31:0] cfg_min;
   logic [31:0] cfg_max;
   rsp_type     codeword_queue[$];

   function automatic logic [31:0] order_key(input logic [31:0] x);
      return cfg_signed ? (x ^ 32'h8000_0000) : x;
   endfunction

   function automatic rsp_type predict_codeword(input req_type w);
      rsp_type     r;
      logic [32:0] gs;
      logic [31:0] kmin, kmax, kv, off;
      logic [63:0] last_gs, groups, idx;
      kmin = order_key(cfg_min);
      kmax = order_key(cfg_max);
      r.result_word = '0;
      r.status = ST_OK;
      r.last_out = w.last_item;
      if (kmin > kmax) begin
         r.status = ST_BOUNDS;
      end else begin
         gs = {1'b0, kmax} - {1'b0, kmin} + 33'd1;
         if (w.func == FUNC_DECODE) begin
            if (gs[32]) r.result_word = {32'd0, w.code_word[31:0]};
            else if (gs == 33'd1) r.result_word = {32'd0, cfg_min};
            else r.result_word = {32'd0, 32'((w.code_word % 64'(gs)) + 64'(cfg_min))};
         end else begin
            kv = order_key(w.value);
            if (kv < kmin) r.status = ST_LOW;
            else if (kv > kmax) r.status = ST_HIGH;
            else if (gs[32]) r.result_word = {w.random_word[31:0], w.value};
            else if (gs == 33'd1) r.result_word = w.random_word;
            else begin
               off = kv - kmin;
               last_gs = ((64'hFFFF_FFFF_FFFF_FFFF % 64'(gs)) + 64'd1) % 64'(gs);
               groups = 64'hFFFF_FFFF_FFFF_FFFF / 64'(gs) + 64'd1;
               if (last_gs == 0 || 64'(off) < last_gs) idx = w.random_word % groups;
               else idx = w.random_word % (groups - 64'd1);
               r.result_word = 64'(off) + idx * 64'(gs);
            end
         end
      end
      return r;
   endfunction

   assign pending = codeword_queue.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cfg_signed <= 1'b0;
         cfg_min <= '0;
         cfg_max <= '1;
         fail_count <= 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_SIGNED_MODE: cfg_signed <= csr_data[0];
               CSR_MIN_VALUE: cfg_min <= csr_data;
               CSR_MAX_VALUE: cfg_max <= csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) codeword_queue.push_back(predict_codeword(req_word));
         if (rsp_valid && rsp_ready) begin
            if (codeword_queue.size() == 0) begin
               $display("%0t: unexpected word, actual %h", $time, rsp_word);
               fail_count <= fail_count + 1;
            end else begin
               want = codeword_queue.pop_front();
               if (want.result_word !== rsp_word.result_word
                   || want.status !== rsp_word.status
                   || want.last_out !== rsp_word.last_out) begin
                  $display("%0t: mismatch, expected %h/%0d/%0d actual %h/%0d/%0d", $time,
                           want.result_word, want.status, want.last_out,
                           rsp_word.result_word, rsp_word.status, rsp_word.last_out);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

/* bench/tb_uniform_int_dte_codec_unit.sv */
`timescale 1ns / 100ps

module tb_uniform_int_dte_codec_unit;
   import udc_pkg::*;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_word;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_type                rsp_word;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;
   int                     fail_count;
   int                     pending;
   int                     send_idle_pct;
   int                     recv_idle_pct;
   logic                   hold_off;
   int                     word_count;
   int                     setting_count;

   uniform_int_dte_codec_unit dut (.*);

   udc_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("FAIL");
      $finish;
   end

   initial begin
      rsp_ready = 1'b0;
      @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_off) rsp_ready <= 1'b0;
         else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
   endtask

   task automatic set_range(input logic sgn, input logic [31:0] lo, input logic [31:0] hi);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (140) @(posedge clock);
      write_reg(CSR_SIGNED_MODE, {31'd0, sgn});
      write_reg(CSR_MIN_VALUE, lo);
      write_reg(CSR_MAX_VALUE, hi);
      csr_write <= 1'b0;
      setting_count++;
   endtask

   task automatic send_word(input logic fn, input logic [31:0] v, input logic [63:0] rw,
                            input logic [63:0] cw);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= '{fn, v, rw, cw, 1'($urandom)};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      word_count++;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic random_burst(input int n, input logic [31:0] lo, input logic [31:0] hi);
      logic [31:0] v;
      logic [31:0] span;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(3))
            0: v = $urandom;
            1: v = lo + $urandom_range(3);
            2: v = hi - $urandom_range(3);
            default: begin
               span = hi - lo + 32'd1;
               if (span == 32'd0) v = $urandom;
               else v = lo + ($urandom % span);
            end
         endcase
         send_word(1'($urandom), v, rand64(), rand64());
      end
   endtask

   initial begin
      logic [31:0] lo, hi;
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      hold_off = 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      word_count = 0;
      setting_count = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // full range at reset values
      send_word(FUNC_ENCODE, 32'hFFFF_FFFF, '1, '0);
      send_word(FUNC_ENCODE, 32'h0, 64'h0, '1);
      send_word(FUNC_DECODE, 32'h0, '1, '1);
      send_word(FUNC_DECODE, '1, '0, '0);
      set_range(1'b0, 32'd10, 32'd20);
      send_word(FUNC_ENCODE, 32'd9, '1, '0);
      send_word(FUNC_ENCODE, 32'd21, '1, '0);
      send_word(FUNC_ENCODE, 32'd10, '1, '0);
      send_word(FUNC_ENCODE, 32'd20, '1, '0);
      send_word(FUNC_DECODE, '0, '0, '1);
      set_range(1'b0, 32'd7, 32'd7);
      send_word(FUNC_ENCODE, 32'd7, '1, '0);
      send_word(FUNC_ENCODE, 32'd8, '1, '0);
      send_word(FUNC_DECODE, '0, '0, '1);
      set_range(1'b0, 32'd20, 32'd10);
      send_word(FUNC_ENCODE, 32'd15, '1, '0);
      send_word(FUNC_DECODE, '0, '0, '1);
      set_range(1'b1, 32'hFFFF_FF00, 32'h100);
      send_word(FUNC_ENCODE, 32'hFFFF_FF00, '1, '0);
      send_word(FUNC_ENCODE, 32'h8000_0000, '1, '0);
      send_word(FUNC_ENCODE, 32'h7FFF_FFFF, '1, '0);
      send_word(FUNC_DECODE, '0, '0, '1);
      set_range(1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
      send_word(FUNC_ENCODE, 32'h1234_5678, '1, '0);
      // drain the pipeline then stall the receiver so the input backs up
      set_range(1'b0, 32'd3, 32'd1000);
      fork
         begin
            hold_off = 1'b1;
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
         end
         random_burst(300, 32'd3, 32'd1000);
      join
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 79 : 0;
         recv_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 31 : 0;
         for (int s = 0; s < 5; s++) begin
            lo = $urandom;
            hi = $urandom;
            if ($urandom_range(3) == 0) hi = lo + $urandom_range(40);
            if (s == 4) begin
               lo = '0;
               hi = '1;
            end
            set_range(1'($urandom), lo, hi);
            random_burst(100, lo, hi);
         end
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (140) @(posedge clock);
      $display("Sent %0d words across %0d range settings, both codec directions.",
               word_count, setting_count);
      if (fail_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
